// ===== rtl/core/sonar_average_beep_mapper_top_assert.svh =====
`ifndef SONAR_AVERAGE_BEEP_MAPPER_TOP_ASSERT_SVH
`define SONAR_AVERAGE_BEEP_MAPPER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define SABM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define SABM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sabm_pkg.sv =====
package sabm_pkg;

    localparam int WINDOW_LEN_DEF = 100;

    localparam int ECHO_W  = 20;
    localparam int DIST_W  = 15;
    localparam int FREQ_W  = 12;
    localparam int DUR_W   = 10;
    localparam int IVL_W   = 17;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 56;

    // distance = sum * 17 / (1000 * window)
    localparam int SPEED_NUM = 17;
    localparam int SPEED_DEN = 1000;

    // tone thresholds in cm and their frequencies
    localparam int TH_1 = 15;
    localparam int TH_2 = 21;
    localparam int TH_3 = 30;
    localparam int TH_4 = 40;
    localparam int TH_5 = 60;
    localparam int FREQ_1 = 2300;
    localparam int FREQ_2 = 2400;
    localparam int FREQ_3 = 2500;
    localparam int FREQ_4 = 2700;
    localparam int FREQ_5 = 3000;

    // duration = (d - 5) * 200 / 40
    localparam int DIST_OFS = 5;
    localparam int DUR_MUL  = 200;
    localparam int DUR_DIV  = 40;
    localparam int DUR_STEP = DUR_MUL / DUR_DIV;

    // interval = d * 250 / 45 + 50 = floor(d * 50 / 9) + 50
    localparam int IVL_MUL   = 50;
    localparam int IVL_X_W   = 21;
    localparam int RECIP9_W  = 20;
    localparam int RECIP9    = 932068;
    localparam int RECIP9_SH = 23;
    localparam int IVL_OFS   = 50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RING,
        ST_DIV,
        ST_MAP,
        ST_HOLD
    } sabm_state_t;

    typedef struct packed {
        logic [IVL_W-1:0]         next_interval_ms;
        logic signed [DUR_W-1:0]  tone_duration_ms;
        logic [FREQ_W-1:0]        tone_freq_hz;
        logic                     tone_on;
        logic                     beep_valid;
        logic [DIST_W-1:0]        avg_distance_cm;
    } sabm_res_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int sum_w(input int n);
        return ECHO_W + $clog2(n);
    endfunction

endpackage

// ===== rtl/core/sonar_average_beep_mapper_top.sv =====
// channel  dir  handshake           tdata                              tuser
// s_       in   s_tvalid/s_tready   echo_us                            update_due
// m_       out  m_tvalid/m_tready   avg_distance_cm .. next_interval   beep_valid
//
// one word at a time: the next input accept waits until the current word has
// passed through every step and is loaded into the output register while it is free
// steps in order: ring read, sum update, reciprocal multiply for the average,
// tone and interval mapping, output register
// synchronous active-low reset clears the ring valid bits, sum and position at once
// a word held in the output register does not block the next input accept,
// a second finished word waits with s_tready low until the output drains
`include "sonar_average_beep_mapper_top_assert.svh"

module sonar_average_beep_mapper_top import sabm_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // echo_us[19:0], zero pad
    input  logic                 s_tuser,   // update_due
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // avg_distance_cm[14:0], tone_on[15], tone_freq_hz[27:16],
    // tone_duration_ms[37:28], next_interval_ms[54:38], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser    // beep_valid
);

    localparam int SUM_W = sum_w(WINDOW_LEN);

    sabm_state_t       state_reg;
    sabm_state_t       state_next;
    logic              accept;
    logic              ring_start;
    logic              div_start;
    logic              map_start;
    logic              out_load;
    logic              slot_free;
    logic              ring_done;
    logic              div_done;
    logic              map_done;
    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] dist_cm;
    logic              due_reg;
    sabm_res_t         map_res;
    sabm_res_t         out_reg;
    logic              m_tvalid_reg;

    sabm_ring #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ring_start),
        .echo    (s_tdata[ECHO_W-1:0]),
        .done    (ring_done),
        .sum     (sum)
    );

    sabm_div #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .sum     (sum),
        .done    (div_done),
        .quo     (dist_cm)
    );

    sabm_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (map_start),
        .dist_cm (dist_cm),
        .due     (due_reg),
        .done    (map_done),
        .res     (map_res)
    );

    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RING;
                end
            end
            ST_RING: begin
                if (ring_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                if (map_done) begin
                    state_next = slot_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        ring_start = 1'b0;
        div_start  = 1'b0;
        map_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                ring_start = s_tvalid;
            end
            ST_RING: begin
                div_start = ring_done;
            end
            ST_DIV: begin
                map_start = div_done;
            end
            ST_MAP: begin
                out_load = map_done && slot_free;
            end
            ST_HOLD: begin
                out_load = slot_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            due_reg <= s_tuser;
        end
        if (out_load) begin
            out_reg <= map_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.beep_valid;
    assign m_tdata  = {1'b0,
                       out_reg.next_interval_ms,
                       out_reg.tone_duration_ms,
                       out_reg.tone_freq_hz,
                       out_reg.tone_on,
                       out_reg.avg_distance_cm};

    `SABM_ASSERT_NEXT(a_one_word_in_flight, accept, !s_tready, "word accepted while busy")
    `SABM_ASSERT_SAME(a_load_into_free_slot, out_load, slot_free, "pending word overwritten")
    `SABM_ASSERT_SAME(a_div_in_sequence, div_done, state_reg == ST_DIV, "divider out of sequence")
    `SABM_ASSERT_SAME(a_quiet_no_due, m_tvalid & ~m_tuser, m_tdata[54:15] == '0, "stray beep fields")

endmodule

// ===== rtl/core/sabm_ram.sv =====
module sabm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sabm_ring.sv =====
module sabm_ring import sabm_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    localparam int POS_W = idx_w(WINDOW_LEN),
    localparam int SUM_W = sum_w(WINDOW_LEN)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ECHO_W-1:0] echo,
    output logic              done,
    output logic [SUM_W-1:0]  sum
);

    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [WINDOW_LEN-1:0] valid_reg;
    logic [ECHO_W-1:0]     echo_reg;
    logic                  st1_reg;
    logic                  done_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [ECHO_W-1:0]     rdata;
    logic [ECHO_W-1:0]     old_echo;

    sabm_ram #(
        .WIDTH (ECHO_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (st1_reg),
        .waddr (pos_reg),
        .wdata (echo_reg),
        .re    (start),
        .raddr (pos_reg),
        .rdata (rdata)
    );

    // entries never written read as zero
    always_comb begin
        old_echo = valid_reg[pos_reg] ? rdata : '0;
        sum_next = sum_reg - SUM_W'(old_echo) + SUM_W'(echo_reg);
        pos_next = (pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            valid_reg <= '0;
            st1_reg   <= 1'b0;
            done_reg  <= 1'b0;
            sum_reg   <= '0;
        end else begin
            st1_reg  <= start;
            done_reg <= st1_reg;
            if (st1_reg) begin
                sum_reg            <= sum_next;
                pos_reg            <= pos_next;
                valid_reg[pos_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            echo_reg <= echo;
        end
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

// ===== rtl/core/sabm_div.sv =====
module sabm_div import sabm_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    localparam int SUM_W = sum_w(WINDOW_LEN),
    localparam longint DEN = longint'(SPEED_DEN) * longint'(WINDOW_LEN),
    localparam int DEN_W = $clog2(DEN + 1),
    localparam int RECIP_SH = SUM_W + DEN_W,
    localparam longint RECIP = ((longint'(SPEED_NUM) << RECIP_SH) + DEN - 1) / DEN,
    localparam int RECIP_W = $clog2(RECIP + 1),
    localparam int PROD_W = SUM_W + RECIP_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SUM_W-1:0]  sum,
    output logic              done,
    output logic [DIST_W-1:0] quo
);

    logic [PROD_W-1:0] prod_reg;
    logic              done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    // sum * 17 / (1000 * window) through a rounded-up reciprocal, exact over the sum range
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= PROD_W'(sum) * PROD_W'(RECIP);
        end
    end

    assign done = done_reg;
    assign quo  = prod_reg[RECIP_SH +: DIST_W];

endmodule

// ===== rtl/core/sabm_map.sv =====
module sabm_map import sabm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIST_W-1:0] dist_cm,
    input  logic              due,
    output logic              done,
    output sabm_res_t         res
);

    localparam int PROD_W = IVL_X_W + RECIP9_W;

    logic                    on_c;
    logic [FREQ_W-1:0]       freq_c;
    logic signed [DUR_W-1:0] dur_c;
    logic [IVL_X_W-1:0]      x_c;

    logic                    s1_reg;
    logic                    s2_reg;
    logic                    done_reg;
    logic [DIST_W-1:0]       d1_reg;
    logic [DIST_W-1:0]       d2_reg;
    logic                    due1_reg;
    logic                    due2_reg;
    logic                    on1_reg;
    logic                    on2_reg;
    logic [FREQ_W-1:0]       freq1_reg;
    logic [FREQ_W-1:0]       freq2_reg;
    logic signed [DUR_W-1:0] dur1_reg;
    logic signed [DUR_W-1:0] dur2_reg;
    logic [IVL_X_W-1:0]      x_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [IVL_W-1:0]        ivl_c;
    sabm_res_t               res_reg;
    sabm_res_t               res_next;

    always_comb begin
        on_c = (dist_cm <= DIST_W'(TH_5));
        if (dist_cm <= DIST_W'(TH_1)) begin
            freq_c = FREQ_W'(FREQ_1);
        end else if (dist_cm <= DIST_W'(TH_2)) begin
            freq_c = FREQ_W'(FREQ_2);
        end else if (dist_cm <= DIST_W'(TH_3)) begin
            freq_c = FREQ_W'(FREQ_3);
        end else if (dist_cm <= DIST_W'(TH_4)) begin
            freq_c = FREQ_W'(FREQ_4);
        end else begin
            freq_c = FREQ_W'(FREQ_5);
        end
        // only used with the tone on, so the narrow wrap is exact
        dur_c = (DUR_W'(dist_cm) - DUR_W'(DIST_OFS)) * DUR_W'(DUR_STEP);
        x_c   = IVL_X_W'(dist_cm) * IVL_X_W'(IVL_MUL);
    end

    // divide by nine through the reciprocal and assemble the result word
    always_comb begin
        ivl_c = IVL_W'(prod_reg >> RECIP9_SH) + IVL_W'(IVL_OFS);
        res_next.avg_distance_cm  = d2_reg;
        res_next.beep_valid       = due2_reg;
        res_next.tone_on          = due2_reg & on2_reg;
        res_next.tone_freq_hz     = (due2_reg && on2_reg) ? freq2_reg : '0;
        res_next.tone_duration_ms = (due2_reg && on2_reg) ? dur2_reg : '0;
        res_next.next_interval_ms = due2_reg ? ivl_c : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            d1_reg    <= dist_cm;
            due1_reg  <= due;
            on1_reg   <= on_c;
            freq1_reg <= freq_c;
            dur1_reg  <= dur_c;
            x_reg     <= x_c;
        end
        if (s1_reg) begin
            d2_reg    <= d1_reg;
            due2_reg  <= due1_reg;
            on2_reg   <= on1_reg;
            freq2_reg <= freq1_reg;
            dur2_reg  <= dur1_reg;
            prod_reg  <= PROD_W'(x_reg) * PROD_W'(RECIP9);
        end
        if (s2_reg) begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== tb/sonar_average_beep_mapper_top_tb.sv =====
`timescale 1ns / 100ps

module sonar_average_beep_mapper_top_tb;
    import sabm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 1500;

    typedef struct {
        logic [ECHO_W-1:0] echo;
        logic              due;
        logic              drain;
    } echo_word_t;

    typedef struct {
        logic [DIST_W-1:0]       dist_cm;
        logic                    beep;
        logic                    tone_on;
        logic [FREQ_W-1:0]       freq;
        logic signed [DUR_W-1:0] dur;
        logic [IVL_W-1:0]        ivl;
    } range_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    echo_word_t    pend_q[$];
    range_report_t report_q[$];

    logic [ECHO_W-1:0] echo_hist[WINDOW_LEN_DEF];
    int                hist_pos = 0;
    longint            hist_sum = 0;

    int     n_err = 0;
    int     n_checked = 0;
    int     n_sent = 0;
    int     src_gap = 0;
    int     sink_hold = 0;
    int     sink_cyc = 0;
    bit     long_hold_done = 0;
    longint cyc_total = 0;

    sonar_average_beep_mapper_top #(
        .WINDOW_LEN(WINDOW_LEN_DEF)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    initial begin
        for (int i = 0; i < WINDOW_LEN_DEF; i++) begin
            echo_hist[i] = '0;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // window average, tone band, duration and next interval for one echo word
    task automatic predict_range_report(input logic [ECHO_W-1:0] echo, input logic due);
        range_report_t r;
        longint        d;
        longint        f;
        longint        dur_l;
        longint        ivl_l;
        hist_sum = hist_sum - echo_hist[hist_pos] + echo;
        echo_hist[hist_pos] = echo;
        hist_pos = (hist_pos + 1 >= WINDOW_LEN_DEF) ? 0 : hist_pos + 1;
        d = (hist_sum * 17) / (1000 * WINDOW_LEN_DEF);
        r.dist_cm = d[DIST_W-1:0];
        r.beep = 1'b0;
        r.tone_on = 1'b0;
        r.freq = '0;
        r.dur = '0;
        r.ivl = '0;
        if (due) begin
            if (d <= 15) f = 2300;
            else if (d <= 21) f = 2400;
            else if (d <= 30) f = 2500;
            else if (d <= 40) f = 2700;
            else if (d <= 60) f = 3000;
            else f = 0;
            r.beep = 1'b1;
            if (f != 0) begin
                dur_l = ((d - 5) * 200) / 40;
                r.tone_on = 1'b1;
                r.freq = f[FREQ_W-1:0];
                r.dur = dur_l[DUR_W-1:0];
            end
            ivl_l = d * 250 / 45 + 50;
            r.ivl = ivl_l[IVL_W-1:0];
        end
        report_q.push_back(r);
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_err++;
        end
    endtask

    task automatic add_word(input logic [ECHO_W-1:0] echo, input logic due);
        echo_word_t w;
        w.echo = echo;
        w.due = due;
        w.drain = 1'b0;
        pend_q.push_back(w);
    endtask

    task automatic add_drain();
        echo_word_t w;
        w.echo = '0;
        w.due = 1'b0;
        w.drain = 1'b1;
        pend_q.push_back(w);
    endtask

    // input side
    always @(posedge aclk) begin : drive_proc
        echo_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_range_report(s_tdata[ECHO_W-1:0], s_tuser);
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0 && pend_q[0].drain) begin
                    // hold off until every result word is back
                    if (report_q.size() == 0) begin
                        pend_q.delete(0);
                    end
                    s_tvalid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    w = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-ECHO_W){1'b0}}, w.echo};
                    s_tuser  <= w.due;
                    src_gap = ((n_sent % 300) < 80) ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output backpressure
    always @(posedge aclk) begin : sink_proc
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            sink_cyc++;
            if (!long_hold_done && n_checked >= 300) begin
                long_hold_done = 1;
                sink_hold = 400;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if ((sink_cyc % 1024) < 200) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
                sink_hold = pick_gap();
            end
        end
    end

    // result checking
    always @(posedge aclk) begin : check_proc
        range_report_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_q.size() == 0) begin
                $error("result word with no expected word pending");
                n_err++;
            end else begin
                e = report_q.pop_front();
                check_field("avg_distance_cm", e.dist_cm, m_tdata[14:0]);
                check_field("beep_valid", e.beep, m_tuser);
                check_field("tone_on", e.tone_on, m_tdata[15]);
                check_field("tone_freq_hz", e.freq, m_tdata[27:16]);
                check_field("tone_duration_ms", e.dur, $signed(m_tdata[37:28]));
                check_field("next_interval_ms", e.ivl, m_tdata[54:38]);
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin : watchdog_proc
        cyc_total++;
        if (cyc_total > CYCLE_LIMIT) begin
            $display("sonar_average_beep_mapper_top regression: fail");
            $finish;
        end
    end

    initial begin : stim_proc
        int  total;
        int  kind;
        int  target;
        int  run_len;
        int  echo_v;
        bit  mid_drain;
        total = 0;
        mid_drain = 0;

        // directed: zero and full-scale echoes, timer both ways, tone off and negative duration
        add_word(20'h00000, 1'b0);
        add_word(20'h00000, 1'b1);
        add_word(20'hFFFFF, 1'b1);
        add_word(20'hFFFFF, 1'b0);
        add_word(20'hFFFFF, 1'b1);
        add_word(20'hAAAAA, 1'b1);
        add_word(20'h55555, 1'b0);
        add_word(20'h00001, 1'b1);
        add_word(20'h80000, 1'b1);
        add_word(20'hF4240, 1'b1);
        repeat (6) add_word(20'h00000, 1'b1);
        add_drain();

        // steady-distance runs so the window settles into each tone band
        while (total < RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            if (kind < 90) begin
                target = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 400)
                                                     : $urandom_range(0, 70);
                run_len = $urandom_range(10, 150);
                repeat (run_len) begin
                    echo_v = target * 1000 / 17 + $urandom_range(0, 80) - 40;
                    if (echo_v < 0) echo_v = 0;
                    add_word(ECHO_W'(echo_v), 1'($urandom_range(0, 1)));
                end
            end else if (kind < 98) begin
                run_len = $urandom_range(1, 5);
                repeat (run_len) add_word(ECHO_W'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                // fill the whole window with full-scale echoes
                run_len = $urandom_range(100, 130);
                repeat (run_len) add_word(20'hFFFFF, 1'($urandom_range(0, 1)));
            end
            total += run_len;
            if (!mid_drain && total >= RANDOM_WORDS / 2) begin
                add_drain();
                mid_drain = 1;
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (report_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (n_err == 0) begin
            $display("sonar_average_beep_mapper_top regression: pass");
        end else begin
            $display("sonar_average_beep_mapper_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sabm_pkg.sv
rtl/core/sabm_ram.sv
rtl/core/sabm_ring.sv
rtl/core/sabm_div.sv
rtl/core/sabm_map.sv
rtl/core/sonar_average_beep_mapper_top.sv
tb/sonar_average_beep_mapper_top_tb.sv
